FILE: src/bfdo_pkg.sv
// Shared types and constants for the drop-oldest message FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfdo_pkg;

  localparam int unsigned MsgW = 32;
  localparam int unsigned OccW = 5;
  localparam int unsigned CfgW = 5;
  localparam logic [CfgW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDropped = 2'd1,
    StEmpty   = 2'd2
  } status_e;

  typedef enum logic {
    OpEnq = 1'b0,
    OpDeq = 1'b1
  } op_e;

endpackage

`default_nettype wire

FILE: src/bfdo_intf.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on bfdo_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bfdo_req_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [bfdo_pkg::MsgW-1:0] message;
  modport source (output valid, operation, message, input ready);
  modport sink   (input valid, operation, message, output ready);
endinterface

interface bfdo_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [bfdo_pkg::MsgW-1:0] message_out;
  logic [bfdo_pkg::OccW-1:0] occupancy;
  modport source (output valid, status, message_out, occupancy, input ready);
  modport sink   (input valid, status, message_out, occupancy, output ready);
endinterface

interface bfdo_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bfdo_pkg::CfgW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: src/bfdo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfdo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/bounded_fifo_drop_oldest_top.sv
// Drop-oldest message FIFO: ring buffer in one RAM, head/tail/count in flops.
// Depends on bfdo_pkg, bfdo_intf, bfdo_ram.
// The response is registered and shows in the cycle after its request is accepted;
// one request per cycle while responses drain (dequeue data read at the accept edge).
// A request is taken whenever the response register is empty or being drained.
// Reset empties the queue and sets the capacity to 16; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_fifo_drop_oldest_top #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned MESSAGE_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfdo_req_if.sink   req_i,
  bfdo_cfg_if.sink   cfg_i,
  bfdo_rsp_if.source rsp_o
);

  import bfdo_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned W  = (CW > CfgW) ? CW : CfgW;

  logic [CfgW-1:0] max_q;
  logic [PW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic            rsp_valid_q, rsp_valid_d;
  status_e         status_q, status_d;
  logic [OccW-1:0] occ_q;
  logic            deq_q, deq_d;

  logic            accept;
  logic            is_enq;
  logic [W-1:0]    cap;
  logic [W-1:0]    max_w;
  logic [W-1:0]    count_w;
  logic [W-1:0]    count_d_w;
  logic [63:0]     msg_wide;
  logic [63:0]     rd_wide;
  logic [MESSAGE_BITS-1:0] wdata;
  logic [MESSAGE_BITS-1:0] rdata;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign is_enq      = (op_e'(req_i.operation) == OpEnq);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= CapReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      max_q <= cfg_i.data;
    end
  end

  assign max_w   = W'(max_q);
  assign count_w = W'(count_q);

  always_comb begin
    if (max_q == '0) begin
      cap = W'(1);
    end else if (max_w > W'(QUEUE_DEPTH)) begin
      cap = W'(QUEUE_DEPTH);
    end else begin
      cap = max_w;
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    status_d    = status_q;
    deq_d       = deq_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (accept) begin
      rsp_valid_d = 1'b1;
      status_d    = StOk;
      deq_d       = 1'b0;
      if (is_enq) begin
        tail_d = ring_next(tail_q);
        if (count_w >= cap) begin
          head_d   = ring_next(head_q);
          status_d = StDropped;
        end else begin
          count_d = count_q + CW'(1);
        end
      end else if (count_q == '0) begin
        status_d = StEmpty;
      end else begin
        deq_d   = 1'b1;
        head_d  = ring_next(head_q);
        count_d = count_q - CW'(1);
      end
    end
  end

  assign count_d_w = W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    deq_q    <= deq_d;
    if (accept) begin
      occ_q <= count_d_w[OccW-1:0];
    end
  end

  assign msg_wide = 64'(req_i.message);
  assign wdata    = msg_wide[MESSAGE_BITS-1:0];

  bfdo_ram #(
    .WIDTH (MESSAGE_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && is_enq),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .re_i    (accept && !is_enq),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign rd_wide           = 64'(rdata);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.message_out = deq_q ? rd_wide[MsgW-1:0] : '0;
  assign rsp_o.occupancy   = occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above storage depth");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && status_q == StEmpty |-> occ_q == '0 && !deq_q)
    else $error("empty response with nonzero occupancy or data");

  a_first_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_enq && count_q == '0 |=> status_q == StOk && count_q == CW'(1))
    else $error("enqueue into empty queue mishandled");
`endif

endmodule

`default_nettype wire
